// File: hdl/ck_pkg.sv
package ck_pkg;

  localparam logic [16:0] KY_R = 17'd19595;
  localparam logic [16:0] KY_G = 17'd38470;
  localparam logic [16:0] KY_B = 17'd7471;
  localparam logic [16:0] KCR  = 17'd46727;
  localparam logic [16:0] KCB  = 17'd36962;

  localparam int DIFF_W = 19;
  localparam int SQ_W   = 36;
  localparam int ROOT_W = SQ_W / 2;
  localparam int DEN_W  = 17;
  localparam int Q_W    = 8;
  localparam int NUM_W  = DEN_W + Q_W;
  localparam int IDX_W  = 4;
  localparam int DATA_W = 9;

  localparam int COLOR_STAGES = 6;
  localparam int MATTE_STAGES = Q_W + 2;
  localparam int BLEND_STAGES = 2;
  localparam int LATENCY = COLOR_STAGES + ROOT_W + MATTE_STAGES + BLEND_STAGES;

  localparam logic [IDX_W-1:0] REG_KEY_BLUE  = 4'd0;
  localparam logic [IDX_W-1:0] REG_KEY_GREEN = 4'd1;
  localparam logic [IDX_W-1:0] REG_KEY_RED   = 4'd2;
  localparam logic [IDX_W-1:0] REG_INNER     = 4'd3;
  localparam logic [IDX_W-1:0] REG_OUTER     = 4'd4;
  localparam logic [IDX_W-1:0] REG_BG_BLUE   = 4'd5;
  localparam logic [IDX_W-1:0] REG_BG_GREEN  = 4'd6;
  localparam logic [IDX_W-1:0] REG_BG_RED    = 4'd7;

  typedef struct packed {
    logic [7:0] b;
    logic [7:0] g;
    logic [7:0] r;
  } pix_t;

endpackage

// File: hdl/chroma_key_matte_and_blend.sv
// chroma key with soft matte and background replacement
// input: one bgr pixel on pixel_blue/green/red, taken when start is high
// and busy is low; busy is high only during reset, so a pixel can be
// taken in every cycle.
// output: done is high for one cycle with matte and out_blue/green/red;
// each item appears in the order in which it was taken.
// throughput is one item per cycle: 6 color/distance stages, 18 square
// root stages (one root bit each), 10 matte stages (8 divider stages, one
// quotient bit each) and 2 blend stages.
// the receiver cannot stall; results are not held.
// configuration: wr_en, wr_index, wr_data write key color, thresholds and
// background; change them only while no item is in flight.
// reset clears the pipeline and loads the default key, thresholds and
// background.
module chroma_key_matte_and_blend (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [7:0]                 pixel_blue,
  input  logic [7:0]                 pixel_green,
  input  logic [7:0]                 pixel_red,
  input  logic                       wr_en,
  input  logic [ck_pkg::IDX_W-1:0]   wr_index,
  input  logic [ck_pkg::DATA_W-1:0]  wr_data,
  output logic                       done,
  output logic [7:0]                 matte,
  output logic [7:0]                 out_blue,
  output logic [7:0]                 out_green,
  output logic [7:0]                 out_red
);
  import ck_pkg::*;

  pix_t key, bg, pix_in, c_pix, s_pix, m_pix, b_pix;
  logic [8:0] inner_threshold, outer_threshold;
  logic accept, c_valid, s_valid, m_valid;
  logic [SQ_W-1:0] dist_sq;
  logic [ROOT_W-1:0] dist_q8;
  logic [7:0] m_matte;

  always_ff @(posedge clk) begin
    if (rst) begin
      key <= '{b: 8'd0, g: 8'd0, r: 8'd0};
      bg  <= '{b: 8'd0, g: 8'd255, r: 8'd0};
      inner_threshold <= 9'd100;
      outer_threshold <= 9'd170;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_KEY_BLUE:  key.b <= wr_data[7:0];
        REG_KEY_GREEN: key.g <= wr_data[7:0];
        REG_KEY_RED:   key.r <= wr_data[7:0];
        REG_INNER:     inner_threshold <= wr_data;
        REG_OUTER:     outer_threshold <= wr_data;
        REG_BG_BLUE:   bg.b <= wr_data[7:0];
        REG_BG_GREEN:  bg.g <= wr_data[7:0];
        REG_BG_RED:    bg.r <= wr_data[7:0];
        default: ;
      endcase
    end
  end

  assign busy   = rst;
  assign accept = start && !busy;
  assign pix_in = '{b: pixel_blue, g: pixel_green, r: pixel_red};

  ck_color u_color (
    .clk(clk), .rst(rst), .in_valid(accept), .pix(pix_in), .key(key),
    .out_valid(c_valid), .pix_out(c_pix), .dist_sq(dist_sq)
  );

  ck_sqrt u_sqrt (
    .clk(clk), .rst(rst), .in_valid(c_valid), .x(dist_sq), .tag_in(c_pix),
    .out_valid(s_valid), .root(dist_q8), .tag_out(s_pix)
  );

  ck_matte u_matte (
    .clk(clk), .rst(rst), .in_valid(s_valid), .dist_q8(dist_q8), .tag_in(s_pix),
    .inner(inner_threshold), .outer(outer_threshold),
    .out_valid(m_valid), .matte(m_matte), .tag_out(m_pix)
  );

  ck_blend u_blend (
    .clk(clk), .rst(rst), .in_valid(m_valid), .matte_in(m_matte), .pix(m_pix),
    .bg(bg), .out_valid(done), .matte(matte), .pix_out(b_pix)
  );

  assign out_blue  = b_pix.b;
  assign out_green = b_pix.g;
  assign out_red   = b_pix.r;

  a_latency: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(accept, LATENCY))
    else $error("result strobe does not follow accepted item");

  a_issue: assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LATENCY done)
    else $error("accepted item gives no result");

  a_fg_pass: assert property (@(posedge clk) disable iff (rst)
    done && matte == 8'd255 |-> out_blue == $past(pixel_blue, LATENCY)
      && out_green == $past(pixel_green, LATENCY)
      && out_red == $past(pixel_red, LATENCY))
    else $error("full foreground does not pass the pixel");

  a_bg_fill: assert property (@(posedge clk) disable iff (rst)
    done && matte == 8'd0 |-> out_blue == bg.b && out_green == bg.g && out_red == bg.r)
    else $error("full background does not give the background color");

endmodule

// File: hdl/ck_color.sv
module ck_color (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  input  ck_pkg::pix_t             pix,
  input  ck_pkg::pix_t             key,
  output logic                     out_valid,
  output ck_pkg::pix_t             pix_out,
  output logic [ck_pkg::SQ_W-1:0]  dist_sq
);
  import ck_pkg::*;

  logic v1, v2, v3, v4, v5;
  pix_t p1, p2, p3, p4, p5;
  logic [24:0] ysum1, ksum1, yr, kr;
  logic [7:0] py, py2, py3, pcr3, pcb3;
  logic [16:0] ky, ky2, ky3;
  logic signed [8:0] dr, db;
  logic signed [26:0] pcr_p2, pcb_p2, pcr_t, pcb_t;
  logic signed [17:0] kdr, kdb;
  logic signed [35:0] kcr_p2, kcb_p2, kcr_t, kcb_t;
  logic signed [DIFF_W-1:0] kcr, kcb, kcr3, kcb3;
  logic signed [DIFF_W-1:0] dy, dcr, dcb, dy4, dcr4, dcb4;
  logic signed [2*DIFF_W-1:0] sy, scr, scb;
  logic [SQ_W-1:0] sy5, scr5, scb5;

  function automatic logic [7:0] clamp8(input logic signed [10:0] v);
    if (v < 0) begin
      return 8'd0;
    end else if (v > 11'sd255) begin
      return 8'd255;
    end
    return v[7:0];
  endfunction

  assign yr = ysum1 + 25'd32768;
  assign py = yr[23:16];
  assign kr = ksum1 + 25'd128;
  assign ky = kr[24:8];
  assign dr = $signed({1'b0, p1.r}) - $signed({1'b0, py});
  assign db = $signed({1'b0, p1.b}) - $signed({1'b0, py});
  assign kdr = $signed({2'b0, key.r, 8'b0}) - $signed({1'b0, ky});
  assign kdb = $signed({2'b0, key.b, 8'b0}) - $signed({1'b0, ky});

  assign pcr_t = (pcr_p2 + 27'sd32768) >>> 16;
  assign pcb_t = (pcb_p2 + 27'sd32768) >>> 16;
  assign kcr_t = (kcr_p2 + 36'sd32768) >>> 16;
  assign kcb_t = (kcb_p2 + 36'sd32768) >>> 16;
  assign kcr = $signed(kcr_t[DIFF_W-1:0]) + 19'sd32768;
  assign kcb = $signed(kcb_t[DIFF_W-1:0]) + 19'sd32768;

  assign dy  = $signed({3'b0, py3, 8'b0}) - $signed({2'b0, ky3});
  assign dcr = $signed({3'b0, pcr3, 8'b0}) - kcr3;
  assign dcb = $signed({3'b0, pcb3, 8'b0}) - kcb3;
  assign sy  = dy4 * dy4;
  assign scr = dcr4 * dcr4;
  assign scb = dcb4 * dcb4;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    p1 <= pix;
    ysum1 <= KY_R * pix.r + KY_G * pix.g + KY_B * pix.b;
    ksum1 <= KY_R * key.r + KY_G * key.g + KY_B * key.b;
    p2 <= p1;
    py2 <= py;
    pcr_p2 <= dr * $signed({1'b0, KCR});
    pcb_p2 <= db * $signed({1'b0, KCB});
    ky2 <= ky;
    kcr_p2 <= kdr * $signed({1'b0, KCR});
    kcb_p2 <= kdb * $signed({1'b0, KCB});
    p3 <= p2;
    py3 <= py2;
    pcr3 <= clamp8($signed(pcr_t[10:0]) + 11'sd128);
    pcb3 <= clamp8($signed(pcb_t[10:0]) + 11'sd128);
    ky3 <= ky2;
    kcr3 <= kcr;
    kcb3 <= kcb;
    p4 <= p3;
    dy4 <= dy;
    dcr4 <= dcr;
    dcb4 <= dcb;
    p5 <= p4;
    sy5 <= sy[SQ_W-1:0];
    scr5 <= scr[SQ_W-1:0];
    scb5 <= scb[SQ_W-1:0];
    pix_out <= p5;
    dist_sq <= sy5 + scr5 + scb5;
  end

endmodule

// File: hdl/ck_sqrt.sv
module ck_sqrt (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [ck_pkg::SQ_W-1:0]    x,
  input  ck_pkg::pix_t               tag_in,
  output logic                       out_valid,
  output logic [ck_pkg::ROOT_W-1:0]  root,
  output ck_pkg::pix_t               tag_out
);
  import ck_pkg::*;

  logic              v      [ROOT_W];
  logic [SQ_W-1:0]   rad    [ROOT_W];
  logic [ROOT_W+1:0] rem    [ROOT_W];
  logic [ROOT_W-1:0] rt     [ROOT_W];
  pix_t              tg     [ROOT_W];
  logic [SQ_W-1:0]   rad_i  [ROOT_W];
  logic [ROOT_W+1:0] rem_i  [ROOT_W];
  logic [ROOT_W-1:0] rt_i   [ROOT_W];
  pix_t              tg_i   [ROOT_W];
  logic [ROOT_W+1:0] sh     [ROOT_W];
  logic [ROOT_W+1:0] trial  [ROOT_W];

  always_comb begin
    rad_i[0] = x;
    rem_i[0] = '0;
    rt_i[0]  = '0;
    tg_i[0]  = tag_in;
    for (int k = 1; k < ROOT_W; k++) begin
      rad_i[k] = rad[k-1];
      rem_i[k] = rem[k-1];
      rt_i[k]  = rt[k-1];
      tg_i[k]  = tg[k-1];
    end
    for (int k = 0; k < ROOT_W; k++) begin
      sh[k]    = {rem_i[k][ROOT_W-1:0], rad_i[k][SQ_W-1 -: 2]};
      trial[k] = {rt_i[k], 2'b01};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < ROOT_W; k++) v[k] <= 1'b0;
    end else begin
      v[0] <= in_valid;
      for (int k = 1; k < ROOT_W; k++) v[k] <= v[k-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < ROOT_W; k++) begin
      rad[k] <= rad_i[k] << 2;
      tg[k]  <= tg_i[k];
      if (sh[k] >= trial[k]) begin
        rem[k] <= sh[k] - trial[k];
        rt[k]  <= {rt_i[k][ROOT_W-2:0], 1'b1};
      end else begin
        rem[k] <= sh[k];
        rt[k]  <= {rt_i[k][ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign out_valid = v[ROOT_W-1];
  assign root      = rt[ROOT_W-1];
  assign tag_out   = tg[ROOT_W-1];

endmodule

// File: hdl/ck_matte.sv
module ck_matte (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic [ck_pkg::ROOT_W-1:0]  dist_q8,
  input  ck_pkg::pix_t               tag_in,
  input  logic [8:0]                 inner,
  input  logic [8:0]                 outer,
  output logic                       out_valid,
  output logic [7:0]                 matte,
  output ck_pkg::pix_t               tag_out
);
  import ck_pkg::*;

  logic [DEN_W-1:0]  lo, hi;
  logic [ROOT_W-1:0] diff;
  logic              fv, fbelow, ffull;
  pix_t              ftag;
  logic [NUM_W-1:0]  fnum;
  logic [DEN_W-1:0]  fden;

  logic              v     [Q_W];
  logic              below [Q_W];
  logic              full  [Q_W];
  pix_t              tg    [Q_W];
  logic [NUM_W-1:0]  rem   [Q_W];
  logic [DEN_W-1:0]  den   [Q_W];
  logic [Q_W-1:0]    q     [Q_W];
  logic              below_i [Q_W];
  logic              full_i  [Q_W];
  pix_t              tg_i    [Q_W];
  logic [NUM_W-1:0]  rem_i   [Q_W];
  logic [DEN_W-1:0]  den_i   [Q_W];
  logic [Q_W-1:0]    q_i     [Q_W];
  logic [NUM_W-1:0]  dsh     [Q_W];

  assign lo   = {inner, 8'b0};
  assign hi   = {outer, 8'b0};
  assign diff = dist_q8 - {1'b0, lo};

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else begin
      fv <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    ftag   <= tag_in;
    fbelow <= dist_q8 < {1'b0, lo};
    ffull  <= (dist_q8 > {1'b0, hi}) || (hi == lo);
    fnum   <= {diff[DEN_W-1:0], 8'b0} - {8'b0, diff[DEN_W-1:0]};
    fden   <= hi - lo;
  end

  always_comb begin
    below_i[0] = fbelow;
    full_i[0]  = ffull;
    tg_i[0]    = ftag;
    rem_i[0]   = fnum;
    den_i[0]   = fden;
    q_i[0]     = '0;
    for (int k = 1; k < Q_W; k++) begin
      below_i[k] = below[k-1];
      full_i[k]  = full[k-1];
      tg_i[k]    = tg[k-1];
      rem_i[k]   = rem[k-1];
      den_i[k]   = den[k-1];
      q_i[k]     = q[k-1];
    end
    for (int k = 0; k < Q_W; k++) begin
      dsh[k] = NUM_W'(den_i[k]) << (Q_W - 1 - k);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < Q_W; k++) v[k] <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v[0] <= fv;
      for (int k = 1; k < Q_W; k++) v[k] <= v[k-1];
      out_valid <= v[Q_W-1];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < Q_W; k++) begin
      below[k] <= below_i[k];
      full[k]  <= full_i[k];
      tg[k]    <= tg_i[k];
      den[k]   <= den_i[k];
      if (rem_i[k] >= dsh[k]) begin
        rem[k] <= rem_i[k] - dsh[k];
        q[k]   <= {q_i[k][Q_W-2:0], 1'b1};
      end else begin
        rem[k] <= rem_i[k];
        q[k]   <= {q_i[k][Q_W-2:0], 1'b0};
      end
    end
    tag_out <= tg[Q_W-1];
    if (below[Q_W-1]) begin
      matte <= 8'd0;
    end else if (full[Q_W-1]) begin
      matte <= 8'd255;
    end else begin
      matte <= q[Q_W-1];
    end
  end

endmodule

// File: hdl/ck_blend.sv
module ck_blend (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [7:0]    matte_in,
  input  ck_pkg::pix_t  pix,
  input  ck_pkg::pix_t  bg,
  output logic          out_valid,
  output logic [7:0]    matte,
  output ck_pkg::pix_t  pix_out
);
  import ck_pkg::*;

  logic       v1;
  logic [7:0] m1;
  logic [15:0] xb, xg, xr;

  function automatic logic [15:0] mix(input logic [7:0] m, input logic [7:0] p,
                                      input logic [7:0] b);
    return {8'b0, m} * {8'b0, p} + {8'b0, ~m} * {8'b0, b} + 16'd127;
  endfunction

  // exact floor(x / 255) for 16-bit x below 65280
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [15:0] t;
    t = x + {8'b0, x[15:8]} + 16'd1;
    return t[15:8];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    m1 <= matte_in;
    xb <= mix(matte_in, pix.b, bg.b);
    xg <= mix(matte_in, pix.g, bg.g);
    xr <= mix(matte_in, pix.r, bg.r);
    matte <= m1;
    pix_out.b <= div255(xb);
    pix_out.g <= div255(xg);
    pix_out.r <= div255(xr);
  end

endmodule
